[rtl/core/rrpc_pkg.sv]
// Shared types, constants and helper functions of the partitioned Rice residual coder.
`timescale 1ns / 1ps
`default_nettype none
package rrpc_pkg;

    localparam int DEF_MAX_BLOCK      = 4096;
    localparam int DEF_MAX_PART_ORDER = 8;
    localparam logic [3:0] RESET_MAX_ORDER = 4'd6;

    localparam int RES_W  = 31;
    localparam int ORD_W  = 6;
    localparam int SUM_W  = 48;
    localparam int N_W    = 17;
    localparam int K_W    = 6;
    localparam int CMP_W  = 64;
    localparam int KEEP_W = 5;

    localparam logic [K_W-1:0]    K_LIMIT    = 6'd40;
    localparam logic [KEEP_W-1:0] ESC_K      = 5'd14;
    localparam logic [4:0]        METHOD_CNT = 5'd2;
    localparam logic [4:0]        PORD_CNT   = 5'd4;
    localparam logic [4:0]        K_CNT_RICE = 5'd4;
    localparam logic [4:0]        K_CNT_ESC  = 5'd5;
    localparam logic [SUM_W-1:0]  PART_HDR_BITS = 48'd4;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ORDER,
        ST_PART,
        ST_SUM,
        ST_COST,
        ST_CMP,
        ST_DRD,
        ST_DOUT
    } state_t;

    typedef enum logic [2:0] {
        E_NONE,
        E_METHOD,
        E_ORDER,
        E_PHDR,
        E_RES
    } phase_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_SRCH,
        C_EST1,
        C_EST2
    } cost_state_t;

    typedef struct packed {
        logic             start;
        logic [N_W-1:0]   n;
        logic [SUM_W-1:0] sum;
    } cost_req_t;

    typedef struct packed {
        logic             done;
        logic [K_W-1:0]   k;
        logic [SUM_W-1:0] est;
    } cost_rsp_t;

    function automatic logic [RES_W-1:0] magnitude(input logic [RES_W-1:0] r);
        magnitude = r[RES_W-1] ? (~r + 1'b1) : r;
    endfunction

    function automatic logic [RES_W-1:0] zigzag(input logic [RES_W-1:0] r);
        zigzag = {r[RES_W-2:0], 1'b0} ^ {RES_W{r[RES_W-1]}};
    endfunction

endpackage
`default_nettype wire

[rtl/core/rrpc_ram.sv]
// Single-port-write, single-port-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rrpc_ram
    import rrpc_pkg::*;
#(
    parameter int WIDTH = RES_W,
    parameter int DEPTH = DEF_MAX_BLOCK
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/rrpc_cost.sv]
// Iterative Rice parameter search and partition cost estimate.
`timescale 1ns / 1ps
`default_nettype none
module rrpc_cost
    import rrpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cost_req_t req,
    output cost_rsp_t      rsp
);

    cost_state_t       state_reg, state_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [SUM_W-1:0]  shf_reg, shf_next;
    logic [23:0]       prod_reg, prod_next;
    logic [SUM_W-1:0]  est_reg, est_next;
    logic              done_reg, done_next;
    logic [CMP_W-1:0]  scaled;

    assign scaled = CMP_W'(n_reg) << k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        sum_reg  <= sum_next;
        k_reg    <= k_next;
        shf_reg  <= shf_next;
        prod_reg <= prod_next;
        est_reg  <= est_next;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        sum_next   = sum_reg;
        k_next     = k_reg;
        shf_next   = shf_reg;
        prod_next  = prod_reg;
        est_next   = est_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    n_next     = req.n;
                    sum_next   = req.sum;
                    k_next     = '0;
                    state_next = C_SRCH;
                end
            end
            C_SRCH:
            begin
                if ((k_reg < K_LIMIT) && (scaled < CMP_W'(sum_reg)))
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = C_EST1;
                end
            end
            C_EST1:
            begin
                shf_next   = (k_reg != '0) ? (sum_reg >> (k_reg - 1'b1)) : (sum_reg << 1);
                prod_next  = 24'(({1'b0, k_reg} + 7'd1) * n_reg);
                state_next = C_EST2;
            end
            C_EST2:
            begin
                est_next   = PART_HDR_BITS + shf_reg + SUM_W'(prod_reg)
                             - SUM_W'(n_reg >> 1);
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.k    = k_reg;
    assign rsp.est  = est_reg;

endmodule
`default_nettype wire

[rtl/core/rice_residual_partition_coder_core.sv]
// Top level of the partitioned Rice residual coder: sequencer, search and word emission.
`timescale 1ns / 1ps
`default_nettype none
// A load transfer (tuser 0) stores one residual while the memory has room. The transfer with tlast
// set starts the partition search, during which s_tready is low: for each tried order the
// stored residuals are read once, one per cycle through the single residual memory port, and
// each partition then uses the shared cost unit, which steps k upward and then forms the
// cost estimate. A drain transfer (tuser 1) yields one code word, read through the same
// memory port and registered once the output register is free; a waiting word does not block
// the next transfer. Loads are ignored while words are pending.
module rice_residual_partition_coder_core
    import rrpc_pkg::*;
#(
    parameter int MAX_BLOCK      = DEF_MAX_BLOCK,
    parameter int MAX_PART_ORDER = DEF_MAX_PART_ORDER
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [3:0]             cfg_data,    // max_partition_order
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,     // residual, predictor_order
    input  wire logic                   s_tuser,     // command
    input  wire logic                   s_tlast,     // last_residual
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,     // zero_count, marker, bits_value, bits_count
    output logic                        m_tlast      // last_word
);

    localparam int AW     = $clog2(MAX_BLOCK);
    localparam int CW     = $clog2(MAX_BLOCK + 1);
    localparam int BW     = $clog2(MAX_BLOCK + 64);
    localparam int PI     = (MAX_PART_ORDER > 0) ? MAX_PART_ORDER : 1;
    localparam int PC_W   = MAX_PART_ORDER + 1;
    localparam int PO_W   = $clog2(MAX_PART_ORDER + 2);
    localparam int TAB_D  = 2 * (1 << PI);

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [3:0]         maxo_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [ORD_W-1:0]   order_reg, order_next;
    logic [PO_W-1:0]    p_reg, p_next;
    logic [PC_W-1:0]    part_reg, part_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [BW-1:0]      left_reg, left_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               pend_reg, pend_next;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic               flag_reg, flag_next;
    logic [SUM_W-1:0]   best_total_reg, best_total_next;
    logic [3:0]         best_order_reg, best_order_next;
    logic               best_sel_reg, best_sel_next;
    logic               method_reg, method_next;
    logic [PC_W-1:0]    emit_part_reg, emit_part_next;
    logic [CW-1:0]      emit_idx_reg, emit_idx_next;
    logic [BW-1:0]      emit_left_reg, emit_left_next;
    logic [KEEP_W-1:0]  emit_k_reg, emit_k_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    logic               st_we, st_re;
    logic [AW-1:0]      st_raddr;
    logic [RES_W-1:0]   st_rdata;
    logic               tab_we, tab_re;
    logic [PI:0]        tab_waddr, tab_raddr;
    logic [KEEP_W-1:0]  tab_wdata, tab_rdata;
    cost_req_t          creq;
    cost_rsp_t          crsp;

    logic               in_acc;
    logic [RES_W-1:0]   in_res;
    logic [ORD_W-1:0]   in_ord;
    logic [BW-1:0]      bs, seg, emit_seg;
    logic [PO_W-1:0]    maxp;
    logic               low_nz;
    logic [RES_W-1:0]   zz;
    logic               out_free;

    assign in_acc    = s_tvalid && s_tready;
    assign in_res    = s_tdata[RES_W-1:0];
    assign in_ord    = s_tdata[RES_W+ORD_W-1:RES_W];
    assign bs        = BW'(count_reg) + BW'(order_reg);
    assign seg       = bs >> p_reg;
    assign emit_seg  = bs >> best_order_reg;
    assign maxp      = (maxo_reg > 4'(MAX_PART_ORDER)) ? PO_W'(MAX_PART_ORDER) : PO_W'(maxo_reg);
    assign low_nz    = |(bs & ~({BW{1'b1}} << p_reg));
    assign zz        = zigzag(st_rdata);
    assign out_free  = !out_valid_reg || m_tready;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    assign st_we     = in_acc && !s_tuser && (phase_reg == E_NONE)
                       && (count_reg < CW'(MAX_BLOCK));
    assign st_raddr  = (state_reg == ST_SUM) ? idx_reg[AW-1:0] : emit_idx_reg[AW-1:0];
    assign st_re     = ((state_reg == ST_SUM) && (left_reg != '0)) || (state_reg == ST_DRD);
    assign tab_we    = (state_reg == ST_COST) && crsp.done;
    assign tab_waddr = {~best_sel_reg, part_reg[PI-1:0]};
    assign tab_wdata = crsp.k[KEEP_W-1:0];
    assign tab_re    = (state_reg == ST_DRD);
    assign tab_raddr = {best_sel_reg, emit_part_reg[PI-1:0]};

    rrpc_ram #(
        .WIDTH (RES_W),
        .DEPTH (MAX_BLOCK)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_res),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    rrpc_ram #(
        .WIDTH (KEEP_W),
        .DEPTH (TAB_D)
    ) u_ktab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    rrpc_cost u_cost (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= E_NONE;
            maxo_reg       <= RESET_MAX_ORDER;
            count_reg      <= '0;
            order_reg      <= '0;
            pend_reg       <= 1'b0;
            best_total_reg <= '1;
            best_order_reg <= '0;
            best_sel_reg   <= 1'b0;
            method_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            if (cfg_valid && cfg_ready)
            begin
                maxo_reg <= cfg_data;
            end
            count_reg      <= count_next;
            order_reg      <= order_next;
            pend_reg       <= pend_next;
            best_total_reg <= best_total_next;
            best_order_reg <= best_order_next;
            best_sel_reg   <= best_sel_next;
            method_reg     <= method_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        part_reg      <= part_next;
        idx_reg       <= idx_next;
        left_reg      <= left_next;
        sum_reg       <= sum_next;
        total_reg     <= total_next;
        flag_reg      <= flag_next;
        emit_part_reg <= emit_part_next;
        emit_idx_reg  <= emit_idx_next;
        emit_left_reg <= emit_left_next;
        emit_k_reg    <= emit_k_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        order_next      = order_reg;
        p_next          = p_reg;
        part_next       = part_reg;
        idx_next        = idx_reg;
        left_next       = left_reg;
        sum_next        = sum_reg;
        pend_next       = 1'b0;
        total_next      = total_reg;
        flag_next       = flag_reg;
        best_total_next = best_total_reg;
        best_order_next = best_order_reg;
        best_sel_next   = best_sel_reg;
        method_next     = method_reg;
        emit_part_next  = emit_part_reg;
        emit_idx_next   = emit_idx_reg;
        emit_left_next  = emit_left_reg;
        emit_k_next     = emit_k_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        creq.start      = 1'b0;
        creq.n          = N_W'(left_reg);
        creq.sum        = sum_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser)
                    begin
                        if (phase_reg != E_NONE)
                        begin
                            state_next = ST_DRD;
                        end
                    end
                    else if (phase_reg == E_NONE)
                    begin
                        if (count_reg == '0)
                        begin
                            order_next = in_ord;
                        end
                        if (count_reg < CW'(MAX_BLOCK))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        if (s_tlast)
                        begin
                            p_next          = '0;
                            best_total_next = '1;
                            best_order_next = '0;
                            state_next      = ST_ORDER;
                        end
                    end
                end
            end
            ST_ORDER:
            begin
                if ((p_reg > maxp) || low_nz)
                begin
                    phase_next = E_METHOD;
                    state_next = ST_IDLE;
                end
                else if (seg <= BW'(order_reg))
                begin
                    p_next = p_reg + 1'b1;
                end
                else
                begin
                    part_next  = '0;
                    idx_next   = '0;
                    total_next = '0;
                    flag_next  = 1'b0;
                    state_next = ST_PART;
                end
            end
            ST_PART:
            begin
                left_next  = (part_reg == '0) ? (seg - BW'(order_reg)) : seg;
                sum_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(magnitude(st_rdata));
                end
                if (left_reg != '0)
                begin
                    idx_next  = idx_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    creq.start = 1'b1;
                    creq.n     = N_W'((part_reg == '0) ? (seg - BW'(order_reg)) : seg);
                    state_next = ST_COST;
                end
            end
            ST_COST:
            begin
                if (crsp.done)
                begin
                    total_next = total_reg + crsp.est;
                    flag_next  = flag_reg || (crsp.k[KEEP_W-1:0] > ESC_K);
                    part_next  = part_reg + 1'b1;
                    if ((part_reg + 1'b1) == (PC_W'(1) << p_reg))
                    begin
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        state_next = ST_PART;
                    end
                end
            end
            ST_CMP:
            begin
                if (total_reg < best_total_reg)
                begin
                    best_total_next = total_reg;
                    best_order_next = 4'(p_reg);
                    best_sel_next   = ~best_sel_reg;
                    method_next     = flag_reg;
                end
                p_next     = p_reg + 1'b1;
                state_next = ST_ORDER;
            end
            ST_DRD:
            begin
                state_next = ST_DOUT;
            end
            ST_DOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    state_next     = ST_IDLE;
                    case (phase_reg)
                        E_METHOD:
                        begin
                            out_data_next = {5'b0, METHOD_CNT, 29'b0, method_reg, 1'b0, 31'b0};
                            phase_next    = E_ORDER;
                        end
                        E_ORDER:
                        begin
                            out_data_next  = {5'b0, PORD_CNT, 26'b0, best_order_reg, 1'b0, 31'b0};
                            emit_part_next = '0;
                            emit_idx_next  = '0;
                            phase_next     = E_PHDR;
                        end
                        E_PHDR:
                        begin
                            out_data_next  = {5'b0, (method_reg ? K_CNT_ESC : K_CNT_RICE),
                                              25'b0, tab_rdata, 1'b0, 31'b0};
                            emit_k_next    = tab_rdata;
                            emit_left_next = (emit_part_reg == '0)
                                             ? (emit_seg - BW'(order_reg)) : emit_seg;
                            phase_next     = E_RES;
                        end
                        E_RES:
                        begin
                            out_data_next = {5'b0, emit_k_reg,
                                             30'(zz & ~({RES_W{1'b1}} << emit_k_reg)),
                                             1'b1, zz >> emit_k_reg};
                            emit_idx_next  = emit_idx_reg + 1'b1;
                            emit_left_next = emit_left_reg - 1'b1;
                            phase_next     = E_RES;
                            if (emit_left_reg == BW'(1))
                            begin
                                emit_part_next = emit_part_reg + 1'b1;
                                phase_next     = E_PHDR;
                            end
                            if ((emit_idx_reg + 1'b1) >= count_reg)
                            begin
                                out_last_next = 1'b1;
                                phase_next    = E_NONE;
                                count_next    = '0;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !m_tready;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_search_idle_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (phase_reg == E_NONE))
        else $error("search running while words are pending");

    a_cost_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        crsp.done |-> (state_reg == ST_COST))
        else $error("cost result outside its wait state");

    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COST) |-> (p_reg <= PO_W'(MAX_PART_ORDER)))
        else $error("partition order beyond limit during search");

    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DOUT))
        else $error("code word appeared without a drain");

endmodule
`default_nettype wire
